### sv/sitp_pkg.sv
// Shared types and constants for the strict integer text parser.
// No dependencies; imported by every module of the block.
`default_nettype none

package sitp_pkg;

    // Parse phases of one string
    typedef enum logic [2:0] {
        PH_LEAD   = 3'd0,
        PH_FIRST  = 3'd1,
        PH_ZERO   = 3'd2,
        PH_PREFIX = 3'd3,
        PH_DIGITS = 3'd4,
        PH_ERROR  = 3'd5
    } phase_t;

    typedef enum logic [1:0] {
        RADIX_DEC = 2'd0,
        RADIX_HEX = 2'd1,
        RADIX_BIN = 2'd2
    } radix_t;

    // Register indexes
    localparam logic REG_SIGNED_MODE    = 1'b0;
    localparam logic REG_FALLBACK_VALUE = 1'b1;

    // ASCII codes
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UB    = 8'h42;
    localparam logic [7:0] CH_UX    = 8'h58;
    localparam logic [7:0] CH_UZ    = 8'h5A;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LB    = 8'h62;
    localparam logic [7:0] CH_LX    = 8'h78;
    localparam logic [7:0] CH_LZ    = 8'h7A;

    // Letter offsets: 'A' - 10 and 'a' - 10
    localparam logic [7:0] UPPER_OFS = 8'd55;
    localparam logic [7:0] LOWER_OFS = 8'd87;

    // Digit value of a byte that is not alphanumeric
    localparam logic [5:0] DIGIT_NONE = 6'd36;

    localparam logic [4:0] BASE_DEC = 5'd10;
    localparam logic [4:0] BASE_HEX = 5'd16;
    localparam logic [4:0] BASE_BIN = 5'd2;

    // Classified text byte, carried from front to back
    typedef struct packed {
        logic       is_term;
        logic       is_ws;
        logic       is_minus;
        logic       is_plus;
        logic       is_zero;
        logic       is_hex_mark;
        logic       is_bin_mark;
        logic [5:0] digit;
    } byte_class_t;

endpackage

`default_nettype wire

### sv/strict_integer_text_parser.sv
// Top level of the strict integer text parser: APB register file, front
// classifier, byte queue and parse back end. Depends on sitp_pkg, sitp_front,
// sitp_queue and sitp_back.
`default_nettype none

// One text byte is accepted per beat on the input channel and the block
// sustains one byte per clock cycle while no terminator waits behind an
// untaken result. A zero byte ends a string and produces exactly one result
// beat: parse_ok, and either the parsed 32-bit pattern or the fallback_value
// register. Accepted bytes are classified on entry and held in a two-entry
// queue; the back end consumes one queued byte per cycle, a held terminator
// apart, through a single shift-add-compare step (base 2, 10 or 16 against
// the signed, negative or unsigned limit). A popped terminator's result beat
// is offered from an output register; only a terminator stalls behind a
// result not yet taken, and the queue takes input meanwhile until it is full.
// Register 0 (byte address 0) is signed_mode, register 1 (byte address 4) is
// fallback_value; write them only while no string is in flight.
module strict_integer_text_parser #(
    parameter int VALUE_BITS = 32
) (
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,

    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  text_byte,

    output logic             out_valid,
    input  wire logic        out_ready,
    output logic             parse_ok,
    output logic [31:0]      result_value
);
    import sitp_pkg::*;

    logic        signed_mode_reg;
    logic        fallback_value_reg_en;
    logic [31:0] fallback_value_reg;
    logic        cfg_write;
    logic        reg_sel;

    byte_class_t in_class;
    byte_class_t head;
    logic        head_valid;
    logic        pop;
    logic        push;

    // Register file: write on the access phase, pready tied high
    assign pready    = 1'b1;
    assign reg_sel   = paddr[2];
    assign cfg_write = psel && penable && pwrite;

    assign fallback_value_reg_en = cfg_write && (reg_sel == REG_FALLBACK_VALUE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            signed_mode_reg    <= 1'b1;
            fallback_value_reg <= 32'd0;
        end
        else
        begin
            if (cfg_write && reg_sel == REG_SIGNED_MODE)
            begin
                signed_mode_reg <= pwdata[0];
            end
            if (fallback_value_reg_en)
            begin
                fallback_value_reg <= pwdata;
            end
        end
    end

    always_comb
    begin
        unique case (reg_sel)
            REG_SIGNED_MODE: prdata = {31'd0, signed_mode_reg};
            default:         prdata = fallback_value_reg;
        endcase
    end

    // Classify the incoming beat
    sitp_front u_front (
        .text_byte  (text_byte),
        .byte_class (in_class)
    );

    // Accept whenever the queue has room
    assign push = in_valid && in_ready;

    sitp_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (in_class),
        .not_full  (in_ready),
        .pop       (pop),
        .not_empty (head_valid),
        .head      (head)
    );

    // Run the parse and hold the result beat
    sitp_back #(
        .VALUE_BITS (VALUE_BITS)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .signed_mode    (signed_mode_reg),
        .fallback_value (fallback_value_reg),
        .head_valid     (head_valid),
        .head           (head),
        .pop            (pop),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .parse_ok       (parse_ok),
        .result_value   (result_value)
    );

endmodule

`default_nettype wire

### sv/sitp_front.sv
// Front end: classifies each accepted text byte.
// Depends on sitp_pkg.
`default_nettype none

module sitp_front (
    input  wire logic [7:0]          text_byte,
    output sitp_pkg::byte_class_t    byte_class
);
    import sitp_pkg::*;

    logic [7:0] digit_wide;

    always_comb
    begin
        if (text_byte >= CH_0 && text_byte <= CH_9)
        begin
            digit_wide = text_byte - CH_0;
        end
        else if (text_byte >= CH_UA && text_byte <= CH_UZ)
        begin
            digit_wide = text_byte - UPPER_OFS;
        end
        else if (text_byte >= CH_LA && text_byte <= CH_LZ)
        begin
            digit_wide = text_byte - LOWER_OFS;
        end
        else
        begin
            digit_wide = {2'b00, DIGIT_NONE};
        end
    end

    always_comb
    begin
        byte_class.is_term     = (text_byte == CH_NUL);
        byte_class.is_ws       = (text_byte == CH_SPACE) ||
                                 (text_byte >= CH_TAB && text_byte <= CH_CR);
        byte_class.is_minus    = (text_byte == CH_MINUS);
        byte_class.is_plus     = (text_byte == CH_PLUS);
        byte_class.is_zero     = (text_byte == CH_0);
        byte_class.is_hex_mark = (text_byte == CH_LX) || (text_byte == CH_UX);
        byte_class.is_bin_mark = (text_byte == CH_LB) || (text_byte == CH_UB);
        byte_class.digit       = digit_wide[5:0];
    end

endmodule

`default_nettype wire

### sv/sitp_queue.sv
// Two-entry queue of classified bytes between front and back.
// Depends on sitp_pkg.
`default_nettype none

module sitp_queue (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 push,
    input  wire sitp_pkg::byte_class_t push_data,
    output logic                      not_full,
    input  wire logic                 pop,
    output logic                      not_empty,
    output sitp_pkg::byte_class_t     head
);
    import sitp_pkg::*;

    byte_class_t entry_reg [2];
    logic        wr_ptr_reg;
    logic        wr_ptr_next;
    logic        rd_ptr_reg;
    logic        rd_ptr_next;
    logic [1:0]  count_reg;
    logic [1:0]  count_next;

    assign not_full  = (count_reg != 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign head      = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Payload: no reset
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

### sv/sitp_back.sv
// Back end: parse state machine, digit accumulator with overflow check,
// and the result register. Depends on sitp_pkg.
`default_nettype none

module sitp_back #(
    parameter int VALUE_BITS = 32
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 signed_mode,
    input  wire logic [31:0]          fallback_value,
    input  wire logic                 head_valid,
    input  wire sitp_pkg::byte_class_t head,
    output logic                      pop,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic                      parse_ok,
    output logic [31:0]               result_value
);
    import sitp_pkg::*;

    localparam int WIDE = VALUE_BITS + 5;
    localparam int RW   = (VALUE_BITS > 32) ? VALUE_BITS : 32;

    phase_t                  phase_reg, phase_next, eff_phase;
    radix_t                  radix_reg, radix_next;
    logic [VALUE_BITS-1:0]   acc_reg, acc_next;
    logic                    neg_reg, neg_next;
    logic                    sign_reg, sign_next;

    logic                    out_valid_reg, out_valid_next;
    logic                    parse_ok_reg, parse_ok_next;
    logic [31:0]             result_value_reg, result_value_next;

    logic                    pop_term;
    logic [4:0]              base;
    logic [WIDE-1:0]         acc_w, prod_sum, limit, umax;
    logic                    digit_bad;
    logic [RW-1:0]           acc_ext, acc_neg;

    assign pop      = head_valid && (!head.is_term || !out_valid_reg || out_ready);
    assign pop_term = pop && head.is_term;

    // A minus seen while unsigned sends the string to failure
    assign eff_phase = (neg_reg && !signed_mode) ? PH_ERROR : phase_reg;

    // Digit step: acc * base + digit, checked against the active limit
    always_comb
    begin
        if (eff_phase == PH_PREFIX || eff_phase == PH_DIGITS)
        begin
            unique case (radix_reg)
                RADIX_HEX: base = BASE_HEX;
                RADIX_BIN: base = BASE_BIN;
                default:   base = BASE_DEC;
            endcase
        end
        else
        begin
            base = BASE_DEC;
        end

        acc_w = WIDE'(acc_reg);
        unique case (base)
            BASE_HEX: prod_sum = (acc_w << 4) + WIDE'(head.digit);
            BASE_BIN: prod_sum = (acc_w << 1) + WIDE'(head.digit);
            default:  prod_sum = (acc_w << 3) + (acc_w << 1) + WIDE'(head.digit);
        endcase

        umax = WIDE'({VALUE_BITS{1'b1}});
        if (neg_reg)
        begin
            limit = (umax >> 1) + WIDE'(1);
        end
        else if (signed_mode)
        begin
            limit = umax >> 1;
        end
        else
        begin
            limit = umax;
        end

        digit_bad = ({1'b0, head.digit} >= {2'b00, base}) || (prod_sum > limit);
    end

    // Next state of the string
    always_comb
    begin
        phase_next = phase_reg;
        radix_next = radix_reg;
        acc_next   = acc_reg;
        neg_next   = neg_reg;
        sign_next  = sign_reg;

        if (pop)
        begin
            if (head.is_term)
            begin
                phase_next = PH_LEAD;
                radix_next = RADIX_DEC;
                acc_next   = '0;
                neg_next   = 1'b0;
                sign_next  = 1'b0;
            end
            else
            begin
                phase_next = eff_phase;
                unique case (eff_phase)
                    PH_LEAD:
                    begin
                        if (head.is_ws)
                        begin
                            phase_next = PH_LEAD;
                        end
                        else if (head.is_minus)
                        begin
                            neg_next   = 1'b1;
                            sign_next  = 1'b1;
                            phase_next = signed_mode ? PH_FIRST : PH_ERROR;
                        end
                        else if (head.is_plus)
                        begin
                            sign_next  = 1'b1;
                            phase_next = PH_FIRST;
                        end
                        else if (head.is_zero)
                        begin
                            phase_next = PH_ZERO;
                        end
                        else
                        begin
                            radix_next = RADIX_DEC;
                            phase_next = digit_bad ? PH_ERROR : PH_DIGITS;
                            if (!digit_bad)
                            begin
                                acc_next = prod_sum[VALUE_BITS-1:0];
                            end
                        end
                    end
                    PH_FIRST:
                    begin
                        if (head.is_zero)
                        begin
                            phase_next = PH_ZERO;
                        end
                        else
                        begin
                            radix_next = RADIX_DEC;
                            phase_next = digit_bad ? PH_ERROR : PH_DIGITS;
                            if (!digit_bad)
                            begin
                                acc_next = prod_sum[VALUE_BITS-1:0];
                            end
                        end
                    end
                    PH_ZERO:
                    begin
                        if (head.is_hex_mark || head.is_bin_mark)
                        begin
                            if (sign_reg)
                            begin
                                phase_next = PH_ERROR;
                            end
                            else
                            begin
                                radix_next = head.is_hex_mark ? RADIX_HEX : RADIX_BIN;
                                phase_next = PH_PREFIX;
                            end
                        end
                        else
                        begin
                            radix_next = RADIX_DEC;
                            phase_next = digit_bad ? PH_ERROR : PH_DIGITS;
                            if (!digit_bad)
                            begin
                                acc_next = prod_sum[VALUE_BITS-1:0];
                            end
                        end
                    end
                    PH_PREFIX, PH_DIGITS:
                    begin
                        phase_next = digit_bad ? PH_ERROR : PH_DIGITS;
                        if (!digit_bad)
                        begin
                            acc_next = prod_sum[VALUE_BITS-1:0];
                        end
                    end
                    default:
                    begin
                        phase_next = PH_ERROR;
                    end
                endcase
            end
        end
    end

    // Result register
    always_comb
    begin
        acc_ext = RW'(acc_reg);
        acc_neg = -acc_ext;

        out_valid_next    = out_valid_reg;
        parse_ok_next     = parse_ok_reg;
        result_value_next = result_value_reg;

        if (pop_term)
        begin
            out_valid_next = 1'b1;
            if (eff_phase == PH_ZERO || eff_phase == PH_DIGITS)
            begin
                parse_ok_next     = 1'b1;
                result_value_next = neg_reg ? acc_neg[31:0] : acc_ext[31:0];
            end
            else
            begin
                parse_ok_next     = 1'b0;
                result_value_next = fallback_value;
            end
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_LEAD;
            radix_reg     <= RADIX_DEC;
            acc_reg       <= '0;
            neg_reg       <= 1'b0;
            sign_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            radix_reg     <= radix_next;
            acc_reg       <= acc_next;
            neg_reg       <= neg_next;
            sign_reg      <= sign_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        parse_ok_reg     <= parse_ok_next;
        result_value_reg <= result_value_next;
    end

    assign out_valid    = out_valid_reg;
    assign parse_ok     = parse_ok_reg;
    assign result_value = result_value_reg;

    // A terminator always leaves a result behind it
    a_term_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        pop_term |=> out_valid_reg)
        else $error("terminator popped without a result");

    // A terminator returns the string state to its start
    a_term_clears: assert property (@(posedge clk) disable iff (!rst_n)
        pop_term |=> (phase_reg == PH_LEAD && acc_reg == '0 && !neg_reg && !sign_reg))
        else $error("string state not cleared after terminator");

    // Nothing accumulates before the number starts
    a_lead_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_LEAD) |-> (acc_reg == '0 && !sign_reg && radix_reg == RADIX_DEC))
        else $error("state held in leading whitespace phase");

endmodule

`default_nettype wire
